// File: src/mlp_pkg.sv
// shared types, constants and the sigmoid rom for the mlp inference block
package mlp_pkg;

  localparam int MAX_LAYERS  = 4;
  localparam int MAX_NEURONS = 16;
  localparam int SIG_DEPTH   = 256;

  localparam int LAYER_W  = $clog2(MAX_LAYERS);
  localparam int NEURON_W = $clog2(MAX_NEURONS);
  localparam int SIG_IDX_W = $clog2(SIG_DEPTH);
  localparam int VAL_W    = 16;
  localparam int OUT_W    = 13;
  localparam int ACC_W    = 36;
  localparam int SIZE_W   = 5;
  localparam int LCNT_W   = 3;

  localparam int WT_DEPTH   = MAX_LAYERS * MAX_NEURONS * MAX_NEURONS;
  localparam int BIAS_DEPTH = MAX_LAYERS * MAX_NEURONS;
  localparam int ACT_DEPTH  = 2 * MAX_NEURONS;

  // half the width of one sigmoid bin
  localparam real BIN_HALF = 8.0 / SIG_DEPTH;

  // input commands
  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_ACT    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_SIZE_IN     = 3'd1;
  localparam logic [2:0] REG_SIZE_L1     = 3'd2;
  localparam logic [2:0] REG_SIZE_L2     = 3'd3;
  localparam logic [2:0] REG_SIZE_L3     = 3'd4;
  localparam logic [2:0] REG_SIZE_L4     = 3'd5;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [1:0] {OP_BIAS, OP_MAC, OP_FIN} op_kind_t;

  typedef struct packed {
    logic     shift;
    op_kind_t kind;
  } ring_ctrl_t;

  typedef logic [OUT_W-1:0] sig_rom_t [SIG_DEPTH];

  // sigmoid at the midpoint of each bin over [-8, 8)
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t rom;
    real      m;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      m = real'(2 * i + 1) * BIN_HALF - 8.0;
      rom[i] = OUT_W'($rtoi(2048.0 + 2048.0 * $tanh(m * 0.5) + 0.5));
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

  // clamp a size register to [1, MAX_NEURONS]
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_W'(MAX_NEURONS)) r = SIZE_W'(MAX_NEURONS);
    return r;
  endfunction

endpackage

// File: src/mlp_ram.sv
// generic simple dual port ram with registered read
module mlp_ram #(
  parameter int W = 16,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: src/mlp_cell.sv
// one accumulator cell of the rotating mac row
module mlp_cell
  import mlp_pkg::*;
(
  input  logic clk,
  input  logic shift,
  input  acc_t d_in,
  output acc_t q
);

  acc_t acc_r;

  always_ff @(posedge clk) begin
    if (shift) acc_r <= d_in;
  end

  assign q = acc_r;

endmodule

// File: src/mlp_mac_row.sv
// ring of accumulator cells with the add at its head
module mlp_mac_row
  import mlp_pkg::*;
(
  input  logic       clk,
  input  ring_ctrl_t ctrl,
  input  acc_t       addend,
  output acc_t       tail
);

  acc_t link [MAX_NEURONS];
  acc_t head_d;

  always_comb begin
    case (ctrl.kind)
      OP_BIAS: head_d = addend;
      OP_MAC:  head_d = link[MAX_NEURONS-1] + addend;
      default: head_d = link[MAX_NEURONS-1];
    endcase
  end

  for (genvar i = 0; i < MAX_NEURONS; i++) begin : g_cell
    acc_t d;
    if (i == 0) begin : g_head
      assign d = head_d;
    end else begin : g_body
      assign d = link[i-1];
    end
    mlp_cell u_cell (
      .clk   (clk),
      .shift (ctrl.shift),
      .d_in  (d),
      .q     (link[i])
    );
  end

  assign tail = link[MAX_NEURONS-1];

endmodule

// File: src/mlp_sigmoid_inference_top.sv
// top level of the fully connected sigmoid network inference block
//
// load items (tuser = cmd) write weights and biases; activation items fill
// input bank 0, and the item whose index is size_in - 1 starts an inference.
// the block then takes no request until the last result has been taken.
// one mac per cycle feeds a ring of MAX_NEURONS accumulator cells; each layer
// runs a bias preload, the macs, a finish pass and a drain, and each result
// waits for the receiver. results come out in neuron order with tlast on the
// final one; all stores are undefined until written.
module mlp_sigmoid_inference_top
  import mlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: layer_sel[1:0], neuron_sel[5:2], elem_index[9:6], value[25:10]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]  in_tuser,
  // out_tdata: out_neuron[3:0], out_value[16:4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_BIAS, ST_MAC, ST_FIN, ST_DRAIN, ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD
  } state_t;

  localparam logic [2:0] DRAIN_LEN = 3'd5;

  // request fields
  logic [1:0]          in_cmd;
  logic [LAYER_W-1:0]  in_lsel;
  logic [NEURON_W-1:0] in_nsel;
  logic [NEURON_W-1:0] in_elem;
  logic [VAL_W-1:0]    in_val;
  logic                in_acc;

  assign in_cmd  = in_tuser;
  assign in_lsel = in_tdata[1:0];
  assign in_nsel = in_tdata[5:2];
  assign in_elem = in_tdata[9:6];
  assign in_val  = in_tdata[25:10];
  assign in_acc  = in_tvalid && in_tready;

  // configuration registers
  logic [LCNT_W-1:0] layer_count_r;
  logic [SIZE_W-1:0] size_in_r;
  logic [SIZE_W-1:0] lsize_r [MAX_LAYERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= LCNT_W'(1);
      size_in_r     <= SIZE_W'(16);
      for (int i = 0; i < MAX_LAYERS; i++) lsize_r[i] <= SIZE_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYER_COUNT: layer_count_r <= cfg_wdata[LCNT_W-1:0];
        REG_SIZE_IN:     size_in_r     <= cfg_wdata;
        REG_SIZE_L1:     lsize_r[0]    <= cfg_wdata;
        REG_SIZE_L2:     lsize_r[1]    <= cfg_wdata;
        REG_SIZE_L3:     lsize_r[2]    <= cfg_wdata;
        REG_SIZE_L4:     lsize_r[3]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t              state_r;
  logic [LAYER_W-1:0]  lay_r;
  logic [NEURON_W-1:0] j_r;
  logic [NEURON_W-1:0] k_r;
  logic                src_r;
  logic [SIZE_W-1:0]   n_prev_r;
  logic [2:0]          drain_r;
  logic                out_valid_r;
  logic [NEURON_W-1:0] out_neuron_r;
  logic [OUT_W-1:0]    out_value_r;
  logic                out_last_r;

  logic [SIZE_W-1:0] n_cur;
  logic [SIZE_W-1:0] n_in;
  logic [LCNT_W-1:0] lc;
  logic              trigger;
  logic              last_layer;

  assign n_cur = clamp_size(lsize_r[lay_r]);
  assign n_in  = clamp_size(size_in_r);

  always_comb begin
    lc = layer_count_r;
    if (layer_count_r == '0) lc = LCNT_W'(1);
    else if (layer_count_r > LCNT_W'(MAX_LAYERS)) lc = LCNT_W'(MAX_LAYERS);
  end

  assign trigger    = in_cmd == CMD_ACT && {1'b0, in_elem} == n_in - SIZE_W'(1);
  assign last_layer = LCNT_W'(lay_r) == lc - LCNT_W'(1);
  assign in_tready  = state_r == ST_IDLE;

  // memories
  logic [VAL_W-1:0] wt_rdata, bias_rdata, act_rdata;
  logic             act_we;
  logic [$clog2(ACT_DEPTH)-1:0] act_waddr, act_raddr;
  logic [VAL_W-1:0] act_wdata;

  logic                g_vld_r;
  logic [NEURON_W-1:0] g_j_r;
  logic [OUT_W-1:0]    g_val_r;

  mlp_ram #(.W(VAL_W), .D(WT_DEPTH)) u_wt_ram (
    .clk   (clk),
    .we    (in_acc && in_cmd == CMD_WEIGHT),
    .waddr ({in_lsel, in_nsel, in_elem}),
    .wdata (in_val),
    .raddr ({lay_r, j_r, k_r}),
    .rdata (wt_rdata)
  );

  mlp_ram #(.W(VAL_W), .D(BIAS_DEPTH)) u_bias_ram (
    .clk   (clk),
    .we    (in_acc && in_cmd == CMD_BIAS),
    .waddr ({in_lsel, in_nsel}),
    .wdata (in_val),
    .raddr ({lay_r, j_r}),
    .rdata (bias_rdata)
  );

  // finish writes go to the bank the current layer does not read
  always_comb begin
    if (g_vld_r) begin
      act_we    = {1'b0, g_j_r} < n_cur;
      act_waddr = {~src_r, g_j_r};
      act_wdata = VAL_W'(g_val_r);
    end else begin
      act_we    = in_acc && in_cmd == CMD_ACT;
      act_waddr = {1'b0, in_elem};
      act_wdata = in_val;
    end
  end

  assign act_raddr = (state_r == ST_MAC) ? {src_r, k_r} : {src_r, j_r};

  mlp_ram #(.W(VAL_W), .D(ACT_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lay_r       <= '0;
      j_r         <= '0;
      k_r         <= '0;
      src_r       <= 1'b0;
      n_prev_r    <= SIZE_W'(1);
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && trigger) begin
            state_r  <= ST_BIAS;
            lay_r    <= '0;
            j_r      <= '0;
            k_r      <= '0;
            src_r    <= 1'b0;
            n_prev_r <= n_in;
          end
        end
        ST_BIAS: begin
          j_r <= j_r + NEURON_W'(1);
          if (j_r == NEURON_W'(MAX_NEURONS - 1)) state_r <= ST_MAC;
        end
        ST_MAC: begin
          j_r <= j_r + NEURON_W'(1);
          if (j_r == NEURON_W'(MAX_NEURONS - 1)) begin
            k_r <= k_r + NEURON_W'(1);
            if ({1'b0, k_r} == n_prev_r - SIZE_W'(1)) begin
              k_r     <= '0;
              state_r <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          j_r <= j_r + NEURON_W'(1);
          if (j_r == NEURON_W'(MAX_NEURONS - 1)) begin
            drain_r <= '0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_r <= drain_r + 3'd1;
          if (drain_r == DRAIN_LEN - 3'd1) begin
            src_r <= ~src_r;
            j_r   <= '0;
            if (last_layer) begin
              state_r <= ST_OUT_RD;
            end else begin
              lay_r    <= lay_r + LAYER_W'(1);
              n_prev_r <= n_cur;
              state_r  <= ST_BIAS;
            end
          end
        end
        ST_OUT_RD: state_r <= ST_OUT_LD;
        ST_OUT_LD: begin
          out_valid_r  <= 1'b1;
          out_neuron_r <= j_r;
          out_value_r  <= act_rdata[OUT_W-1:0];
          out_last_r   <= {1'b0, j_r} == n_cur - SIZE_W'(1);
          state_r      <= ST_OUT_HOLD;
        end
        ST_OUT_HOLD: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            j_r         <= j_r + NEURON_W'(1);
            state_r     <= out_last_r ? ST_IDLE : ST_OUT_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // issue slot of the op stream
  logic     iss_vld;
  op_kind_t iss_kind;

  always_comb begin
    iss_vld  = 1'b1;
    iss_kind = OP_MAC;
    unique case (state_r)
      ST_BIAS: iss_kind = OP_BIAS;
      ST_MAC:  iss_kind = OP_MAC;
      ST_FIN:  iss_kind = OP_FIN;
      default: iss_vld  = 1'b0;
    endcase
  end

  // stage 1: ram data, stage 2: addend into the ring
  logic                s1_vld_r, s2_vld_r;
  op_kind_t            s1_kind_r, s2_kind_r;
  logic [NEURON_W-1:0] s1_j_r, s2_j_r;
  acc_t                s2_add_r;
  logic signed [2*VAL_W-1:0] prod;

  assign prod = $signed(act_rdata) * $signed(wt_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= iss_vld;
      s2_vld_r <= s1_vld_r;
    end
    s1_kind_r <= iss_kind;
    s1_j_r    <= j_r;
    s2_kind_r <= s1_kind_r;
    s2_j_r    <= s1_j_r;
    if (s1_kind_r == OP_BIAS) s2_add_r <= ACC_W'($signed(bias_rdata)) <<< 12;
    else                      s2_add_r <= ACC_W'(prod);
  end

  ring_ctrl_t ring_ctrl;
  acc_t       ring_tail;

  assign ring_ctrl.shift = s2_vld_r;
  assign ring_ctrl.kind  = s2_kind_r;

  mlp_mac_row u_row (
    .clk    (clk),
    .ctrl   (ring_ctrl),
    .addend (s2_add_r),
    .tail   (ring_tail)
  );

  // finish path: round half up, saturate, table index
  logic signed [ACC_W:0]   rnd_sum;
  logic signed [ACC_W-12:0] rnd_q;
  logic signed [VAL_W-1:0] sat_q;

  assign rnd_sum = {ring_tail[ACC_W-1], ring_tail} + (ACC_W+1)'(2048);
  assign rnd_q   = rnd_sum[ACC_W:12];

  always_comb begin
    if (rnd_q > (ACC_W-11)'(32767))       sat_q = 16'sh7fff;
    else if (rnd_q < -(ACC_W-11)'(32768)) sat_q = 16'sh8000;
    else                                  sat_q = rnd_q[VAL_W-1:0];
  end

  logic                 f_vld_r;
  logic [NEURON_W-1:0]  f_j_r;
  logic [SIG_IDX_W-1:0] f_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
    end else begin
      f_vld_r <= s2_vld_r && s2_kind_r == OP_FIN;
      g_vld_r <= f_vld_r;
    end
    f_j_r   <= s2_j_r;
    f_idx_r <= {~sat_q[VAL_W-1], sat_q[VAL_W-2 -: SIG_IDX_W-1]};
    g_j_r   <= f_j_r;
    g_val_r <= SIG_ROM[f_idx_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_value_r, out_neuron_r};
  assign out_tlast  = out_last_r;

  // no result pending while requests are taken
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("result pending while idle");

  // the final result returns the block to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("not idle after last result");

  // layer writeback only happens during an inference
  a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    g_vld_r |-> !in_tready && !out_tvalid)
    else $error("activation writeback outside compute");

endmodule

// File: tb/sv/mlp_forward_checker.sv
// checker: watches the request, result and register ports, predicts and compares results
`timescale 1ns / 100ps
module mlp_forward_checker
  import mlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [3:0]  neuron;
    logic [12:0] level;
    logic        last;
  } act_result_t;

  act_result_t        expected_outputs[$];
  logic signed [15:0] weights [MAX_LAYERS][MAX_NEURONS][MAX_NEURONS];
  logic signed [15:0] biases [MAX_LAYERS][MAX_NEURONS];
  logic signed [15:0] act_bank [2][MAX_NEURONS];
  logic [12:0]        sigmoid_lut [256];
  logic [2:0]         n_layers_reg;
  logic [4:0]         n_inputs_reg;
  logic [4:0]         layer_width_reg [4];

  function automatic logic [12:0] sigmoid_point(int i);
    longint          xm;
    longint unsigned u, term, sum, e, d;
    xm = -524288 + (longint'(2 * i + 1) * 524288) / 256;
    u = (xm < 0 ? -xm : xm) << 11;
    term = 64'd1 << 30;
    sum = term;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * u) >> 30) / k;
      if (k % 2 == 1) sum = (sum >= term) ? sum - term : 0;
      else sum = sum + term;
    end
    e = sum;
    repeat (3) e = (e * e) >> 30;
    d = (64'd1 << 30) + e;
    if (xm >= 0) return 13'(((64'd1 << 42) + d / 2) / d);
    return 13'(((e << 12) + d / 2) / d);
  endfunction

  function automatic int clamp_width(logic [4:0] s);
    if (s == 0) return 1;
    if (s > 16) return 16;
    return int'(s);
  endfunction

  function automatic logic [12:0] neuron_level(int l, int j, int src, int n_prev);
    longint acc, r;
    acc = longint'(biases[l][j]) * 4096;
    for (int k = 0; k < n_prev; k++)
      acc += longint'(act_bank[src][k]) * longint'(weights[l][j][k]);
    r = (acc + 2048) >>> 12;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return sigmoid_lut[(r + 32768) >> 8];
  endfunction

  // evaluate every layer and queue the final layer's results
  task automatic run_forward_pass();
    int          lc, n_prev, n, src;
    logic [12:0] tmp [MAX_NEURONS];
    act_result_t res;
    lc = (n_layers_reg == 0) ? 1 : (n_layers_reg > 4 ? 4 : int'(n_layers_reg));
    n_prev = clamp_width(n_inputs_reg);
    n = 1;
    src = 0;
    for (int l = 0; l < lc; l++) begin
      n = clamp_width(layer_width_reg[l]);
      for (int j = 0; j < n; j++) tmp[j] = neuron_level(l, j, src, n_prev);
      src ^= 1;
      for (int j = 0; j < n; j++) act_bank[src][j] = {3'b0, tmp[j]};
      n_prev = n;
    end
    for (int j = 0; j < n; j++) begin
      res.neuron = 4'(j);
      res.level = act_bank[src][j][12:0];
      res.last = (j == n - 1);
      expected_outputs = {expected_outputs, res};
    end
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < 256; i++) sigmoid_lut[i] = sigmoid_point(i);
  end

  assign pending = expected_outputs.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      n_layers_reg <= 3'd1;
      n_inputs_reg <= 5'd16;
      for (int i = 0; i < 4; i++) layer_width_reg[i] <= 5'd16;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected result neuron=%0d value=%0d", out_tdata[3:0], out_tdata[16:4]);
          fail_count++;
        end else begin
          act_result_t want;
          want = expected_outputs.pop_front();
          if (out_tdata[3:0] !== want.neuron) begin
            $error("out_neuron expected %0d actual %0d", want.neuron, out_tdata[3:0]);
            fail_count++;
          end
          if (out_tdata[16:4] !== want.level) begin
            $error("out_value expected %0d actual %0d", want.level, out_tdata[16:4]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last expected %0d actual %0d", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_WEIGHT: weights[in_tdata[1:0]][in_tdata[5:2]][in_tdata[9:6]] = in_tdata[25:10];
          CMD_BIAS:   biases[in_tdata[1:0]][in_tdata[5:2]] = in_tdata[25:10];
          CMD_ACT: begin
            act_bank[0][in_tdata[9:6]] = in_tdata[25:10];
            if (int'(in_tdata[9:6]) == clamp_width(n_inputs_reg) - 1) run_forward_pass();
          end
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LAYER_COUNT: n_layers_reg <= cfg_wdata[2:0];
          REG_SIZE_IN:     n_inputs_reg <= cfg_wdata;
          REG_SIZE_L1:     layer_width_reg[0] <= cfg_wdata;
          REG_SIZE_L2:     layer_width_reg[1] <= cfg_wdata;
          REG_SIZE_L3:     layer_width_reg[2] <= cfg_wdata;
          REG_SIZE_L4:     layer_width_reg[3] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/sv/tb_mlp_sigmoid_inference_top.sv
// testbench top: clock, reset, stimulus and verdict for the mlp inference block
`timescale 1ns / 100ps
module tb_mlp_sigmoid_inference_top;
  import mlp_pkg::*;

  // the one command the block ignores
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 900000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [4:0]  cfg_wdata = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          sent = 0;

  // which store entries the stimulus has written, so nothing unwritten is read
  bit          w_done [MAX_LAYERS][MAX_NEURONS][MAX_NEURONS];
  bit          b_done [MAX_LAYERS][MAX_NEURONS];
  bit          a_done [MAX_NEURONS];
  // shadow of the register settings, clamped the way the block clamps them
  int          n_layers, n_inputs;
  int          widths [4];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mlp_sigmoid_inference_top DUT (.*);

  mlp_forward_checker u_checker (.*);

  // receiver stalls at random, decided per cycle
  always @(negedge clk) out_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL mlp_sigmoid_inference_top");
      $finish;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int clamp_cfg(int s, int hi);
    if (s < 1) return 1;
    if (s > hi) return hi;
    return s;
  endfunction

  // one request; called and returning at a falling edge
  task automatic send_request(logic [1:0] cmd, int lsel, int nsel, int elem, logic [15:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser = cmd;
    in_tdata = {6'b0, v, 4'(elem), 4'(nsel), 2'(lsel)};
    in_tvalid = 1'b1;
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
    sent++;
    if (cmd == CMD_WEIGHT) w_done[lsel][nsel][elem] = 1;
    if (cmd == CMD_BIAS) b_done[lsel][nsel] = 1;
    if (cmd == CMD_ACT) a_done[elem] = 1;
  endtask

  task automatic write_reg(logic [2:0] idx, int v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = 5'(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // all results in, then a margin for a load still in flight
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic configure(int lc, int sin, int s1, int s2, int s3, int s4);
    write_reg(REG_LAYER_COUNT, lc);
    write_reg(REG_SIZE_IN, sin);
    write_reg(REG_SIZE_L1, s1);
    write_reg(REG_SIZE_L2, s2);
    write_reg(REG_SIZE_L3, s3);
    write_reg(REG_SIZE_L4, s4);
    n_layers = clamp_cfg(lc, 4);
    n_inputs = clamp_cfg(sin, 16);
    widths = '{clamp_cfg(s1, 16), clamp_cfg(s2, 16), clamp_cfg(s3, 16), clamp_cfg(s4, 16)};
  endtask

  // noise: loads anywhere, ignored commands, activations that do not trigger
  task automatic send_noise();
    int e;
    case ($urandom_range(3))
      0: send_request(CMD_WEIGHT, $urandom_range(3), $urandom_range(15), $urandom_range(15),
                      pick_value());
      1: send_request(CMD_BIAS, $urandom_range(3), $urandom_range(15), $urandom_range(15),
                      pick_value());
      2: send_request(CMD_NOP, $urandom_range(3), $urandom_range(15), $urandom_range(15),
                      pick_value());
      default: begin
        e = $urandom_range(15);
        if (e == n_inputs - 1) e = (e + 1) % 16;
        if (n_inputs > 1 || e != 0)
          send_request(CMD_ACT, $urandom_range(3), $urandom_range(15), e, pick_value());
      end
    endcase
  endtask

  // well-formed inference: inputs in random order, missing parameters, then the trigger
  task automatic run_inference(bit allow_stale);
    int order [16];
    int n_prev, j, tmp;
    for (int k = 0; k < 16; k++) order[k] = k;
    for (int k = 15; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < 16; k++) begin
      if (order[k] < n_inputs - 1 &&
          !(allow_stale && a_done[order[k]] && $urandom_range(4) == 0))
        send_request(CMD_ACT, $urandom_range(3), $urandom_range(15), order[k], pick_value());
      if ($urandom_range(7) == 0) send_noise();
    end
    repeat ($urandom_range(6))
      send_request(CMD_WEIGHT, $urandom_range(n_layers - 1), $urandom_range(15),
                   $urandom_range(15), pick_value());
    n_prev = n_inputs;
    for (int l = 0; l < n_layers; l++) begin
      for (int n = 0; n < widths[l]; n++) begin
        if (!b_done[l][n])
          send_request(CMD_BIAS, l, n, $urandom_range(15), pick_value());
        for (int k = 0; k < n_prev; k++)
          if (!w_done[l][n][k]) send_request(CMD_WEIGHT, l, n, k, pick_value());
      end
      n_prev = widths[l];
    end
    send_request(CMD_ACT, $urandom_range(3), $urandom_range(15), n_inputs - 1, pick_value());
  endtask

  initial begin
    int target;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < 6; phase++) begin
      // sender/receiver idling: light/heavy, then heavy/light, then none
      tx_idle_pct = (phase < 2) ? 16 : (phase < 4 ? 63 : 0);
      rx_idle_pct = (phase < 2) ? 63 : (phase < 4 ? 16 : 0);
      case (phase)
        0: configure(1, 16, 2, 16, 16, 16);
        1: configure(0, 1, 0, 31, 17, 1);
        2: configure(4, 3, 2, 3, 1, 4);
        3: configure(7, 31, 2, 3, 2, 1);
        4: configure(2, $urandom_range(31), $urandom_range(4), $urandom_range(8), 1, 1);
        default: configure(3, $urandom_range(1, 6), $urandom_range(1, 6),
                           $urandom_range(1, 6), $urandom_range(1, 6), 2);
      endcase

      if (phase == 0) begin
        // directed: extremes of every field, the ignored command, saturating sums
        send_request(CMD_NOP, 3, 15, 15, 16'hffff);
        send_request(CMD_NOP, 0, 0, 0, 16'h0000);
        for (int k = 0; k < 16; k++) begin
          send_request(CMD_WEIGHT, 0, 0, k, 16'h7fff);
          send_request(CMD_WEIGHT, 0, 1, k, 16'h8000);
        end
        send_request(CMD_BIAS, 0, 0, 0, 16'h7fff);
        send_request(CMD_BIAS, 0, 1, 15, 16'h8000);
        send_request(CMD_BIAS, 3, 7, 0, 16'h0000);
        send_request(CMD_WEIGHT, 3, 15, 15, 16'h0001);
        for (int k = 0; k < 15; k++) send_request(CMD_ACT, 3, 15, k, 16'h7fff);
        run_inference(0);
        for (int k = 0; k < 16; k++) send_request(CMD_ACT, 0, 0, k, 16'h8000);
        for (int k = 0; k < 16; k++) send_request(CMD_ACT, 0, 0, k, 16'h0000);
      end

      target = sent + 35;
      while (sent < target) begin
        if ($urandom_range(4) == 0) send_noise();
        else run_inference(1);
      end
      wait_drained();
    end

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS mlp_sigmoid_inference_top");
    end else begin
      $display("FAIL mlp_sigmoid_inference_top");
    end
    $finish;
  end

endmodule

// File: files.f
src/mlp_pkg.sv
src/mlp_ram.sv
src/mlp_cell.sv
src/mlp_mac_row.sv
src/mlp_sigmoid_inference_top.sv
tb/sv/mlp_forward_checker.sv
tb/sv/tb_mlp_sigmoid_inference_top.sv
